// ===== rtl/sacl_pkg.sv =====
// Package for the set-associative LRU tag store.
// Holds default sizes, field widths, register indexes and the control state type.
// No dependencies; imported by sacl_lookup, the top level and the testbench.
package sacl_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MaxWaysDef   = 8;
  localparam int unsigned MaxSetsDef   = 256;
  localparam int unsigned AddrWidthDef = 32;

  // Width of the access counter and of the per-line stamps.
  localparam int unsigned STAMP_W = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;

  // Raw set index before reduction: index_bits can ask for up to 15 bits.
  localparam int unsigned IDX_RAW_W = 15;
  // Sum of offset and index widths (31 + 15 at most).
  localparam int unsigned SHIFT_W   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgWritePolicy = 2'd0,
    CfgOffsetBits  = 2'd1,
    CfgIndexBits   = 2'd2,
    CfgWaysInUse   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StReduce,
    StLookup
  } state_e;

  localparam logic PolicyWriteBack    = 1'b0;
  localparam logic PolicyWriteThrough = 1'b1;
  localparam logic ModeWrite          = 1'b1;

endpackage

// ===== rtl/sacl_lookup.sv =====
// Tag compare and LRU victim selection over the ways of one set.
// Depends on sacl_pkg for the stamp width.
module sacl_lookup import sacl_pkg::*; #(
  parameter int unsigned MAX_WAYS   = MaxWaysDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef
) (
  input  logic [MAX_WAYS-1:0]                 valid_i,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag_i,
  input  logic [MAX_WAYS-1:0][STAMP_W-1:0]    stamp_i,
  input  logic [ADDR_WIDTH-1:0]               req_tag_i,
  input  logic [3:0]                          ways_i,
  output logic [MAX_WAYS-1:0]                 match_o,
  output logic [MAX_WAYS-1:0]                 victim_o
);

  logic [4:0]          ways_eff;
  logic [MAX_WAYS-1:0] way_en;
  logic [MAX_WAYS-1:0] is_min;
  logic [MAX_WAYS-1:0] first_inv;

  // A way count of zero acts as one; counts above the built ways saturate.
  always_comb begin
    if (ways_i == 4'd0) begin
      ways_eff = 5'd1;
    end else if (5'(ways_i) > 5'(MAX_WAYS)) begin
      ways_eff = 5'(MAX_WAYS);
    end else begin
      ways_eff = 5'(ways_i);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      way_en[w] = 5'(w) < ways_eff;
    end
  end

  // First valid way whose tag matches.
  always_comb begin
    logic found;
    found   = 1'b0;
    match_o = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_en[w] && valid_i[w] && (tag_i[w] == req_tag_i) && !found) begin
        match_o[w] = 1'b1;
        found      = 1'b1;
      end
    end
  end

  // Oldest way: a way wins when its stamp is below every lower way's stamp and
  // not above any higher way's stamp, so ties go to the lowest way.
  always_comb begin
    logic oldest;
    for (int i = 0; i < MAX_WAYS; i++) begin
      oldest = way_en[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j != i && way_en[j]) begin
          if (j < i) begin
            oldest = oldest && (stamp_i[i] < stamp_i[j]);
          end else begin
            oldest = oldest && (stamp_i[i] <= stamp_i[j]);
          end
        end
      end
      is_min[i] = oldest;
    end
  end

  // An empty way in use always takes precedence over the LRU choice.
  always_comb begin
    logic found;
    found     = 1'b0;
    first_inv = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (way_en[w] && !valid_i[w] && !found) begin
        first_inv[w] = 1'b1;
        found        = 1'b1;
      end
    end
    victim_o = found ? first_inv : is_min;
  end

endmodule

// ===== rtl/set_assoc_lru_cache_tags.sv =====
// Top level of the set-associative LRU tag store with write-back or write-through policy.
// Depends on sacl_pkg and instantiates sacl_lookup.
//
// Usage: an item (address_i, mode_i) is taken at a rising edge where start is high and
// busy is low. The address is split into tag and set with the configured offset and index
// widths, the set's row (all ways side by side) is read from a two-port row memory,
// compared, updated and written back. Exactly one result item follows each accepted item:
// hit_o is valid while done_o is high, for exactly one cycle; the receiver cannot stall.
//
// Sequence: with a power-of-two MAX_SETS the row read is issued at the accept edge, the
// lookup and write-back happen in the next cycle, and done_o is high in the cycle after
// that. busy is low again in that same cycle, so a new item is taken only after the
// previous one is written back. With any other MAX_SETS the set index is first reduced
// modulo MAX_SETS by a reciprocal multiplication in the StReduce state, which then issues
// the row read. With one read port and one write-back per item, an item never overlaps
// the write-back of the previous one, so same-set accesses need no forwarding.
//
// Reset: control and configuration registers take their reset values and the row memory
// is swept clean, one set per cycle, with busy high throughout. Configuration writes
// (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once and belong between items.
module set_assoc_lru_cache_tags import sacl_pkg::*; #(
  parameter int unsigned MAX_WAYS   = MaxWaysDef,
  parameter int unsigned MAX_SETS   = MaxSetsDef,
  parameter int unsigned ADDR_WIDTH = AddrWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Access channel.
  input  logic                  start,
  output logic                  busy,
  input  logic [ADDR_WIDTH-1:0] address_i,
  input  logic                  mode_i,
  // Result channel.
  output logic                  done_o,
  output logic                  hit_o,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam bit          SETS_POW2 = (MAX_SETS & (MAX_SETS - 1)) == 0;
  // Rounded-up reciprocal of MAX_SETS; exact quotients for every raw index value.
  localparam int unsigned RECIP_W   = IDX_RAW_W + 2;
  localparam int unsigned PROD_W    = IDX_RAW_W + RECIP_W;
  localparam int unsigned RECIP_SH  = IDX_RAW_W + SET_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS));

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [ADDR_WIDTH-1:0] tag;
    logic [STAMP_W-1:0]    stamp;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Configuration registers.
  logic            policy_q;
  logic [4:0]      offset_q;
  logic [3:0]      index_bits_q;
  logic [3:0]      ways_q;

  // Control and request registers.
  state_e                state_q, state_d;
  logic [SET_W-1:0]      clr_q, clr_d;
  logic [ADDR_WIDTH-1:0] tag_q, tag_d;
  logic                  write_q, write_d;
  logic [SET_W-1:0]      set_q, set_d;
  logic [IDX_RAW_W-1:0]  rem_q, rem_d;
  logic [STAMP_W-1:0]    count_q, count_d;
  logic                  done_q, done_d;
  logic                  hit_q, hit_d;

  // Row memory and its ports.
  row_t             row_mem [MAX_SETS];
  row_t             rd_row_q;
  logic             mem_re;
  logic [SET_W-1:0] mem_raddr;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  // Address decode.
  logic                             accept;
  logic [SHIFT_W-1:0]               shift_sum;
  logic [ADDR_WIDTH-1:0]            req_tag;
  logic [ADDR_WIDTH+IDX_RAW_W-1:0]  addr_shifted;
  logic [IDX_RAW_W-1:0]             idx_mask;
  logic [IDX_RAW_W-1:0]             idx_raw;
  logic [SET_W-1:0]                 set_direct;
  logic [PROD_W-1:0]                rem_prod;
  logic [IDX_RAW_W-1:0]             rem_quot;
  logic [IDX_RAW_W-1:0]             rem_red;

  // Lookup results and the updated row.
  logic [MAX_WAYS-1:0]                 row_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] row_tag;
  logic [MAX_WAYS-1:0][STAMP_W-1:0]    row_stamp;
  logic [MAX_WAYS-1:0]                 match;
  logic [MAX_WAYS-1:0]                 victim;
  logic                                hit_any;
  logic                                victim_dirty;
  logic [STAMP_W-1:0]                  stamp_new;
  row_t                                new_row;
  logic                                new_hit;

  assign accept = start && !busy;
  assign busy   = state_q != StIdle;
  assign done_o = done_q;
  assign hit_o  = hit_q;

  // Configuration registers are written whenever the enable is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q     <= PolicyWriteBack;
      offset_q     <= 5'd2;
      index_bits_q <= 4'd0;
      ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CfgWritePolicy: policy_q     <= cfg_wdata_i[0];
        CfgOffsetBits:  offset_q     <= cfg_wdata_i[4:0];
        CfgIndexBits:   index_bits_q <= cfg_wdata_i[3:0];
        CfgWaysInUse:   ways_q       <= cfg_wdata_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // The tag is everything above offset and index; shifts past the address give zero.
  always_comb begin
    shift_sum    = SHIFT_W'(offset_q) + SHIFT_W'(index_bits_q);
    req_tag      = address_i >> shift_sum;
    addr_shifted = {{IDX_RAW_W{1'b0}}, address_i} >> offset_q;
    idx_mask     = ~({IDX_RAW_W{1'b1}} << index_bits_q);
    idx_raw      = addr_shifted[IDX_RAW_W-1:0] & idx_mask;
    set_direct   = SET_W'(idx_raw & IDX_RAW_W'(MAX_SETS - 1));
    // Modulo reduction for non-power-of-two set counts: quotient by the reciprocal,
    // then the remainder by one constant multiply and subtract.
    rem_prod     = PROD_W'(rem_q) * PROD_W'(RECIP);
    rem_quot     = IDX_RAW_W'(rem_prod >> RECIP_SH);
    rem_red      = rem_q - IDX_RAW_W'(rem_quot * IDX_RAW_W'(MAX_SETS));
  end

  // Unpack the row that was read for the compare logic.
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_valid[w] = rd_row_q[w].valid;
      row_tag[w]   = rd_row_q[w].tag;
      row_stamp[w] = rd_row_q[w].stamp;
    end
  end

  sacl_lookup #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_lookup (
    .valid_i   (row_valid),
    .tag_i     (row_tag),
    .stamp_i   (row_stamp),
    .req_tag_i (tag_q),
    .ways_i    (ways_q),
    .match_o   (match),
    .victim_o  (victim)
  );

  // Row update. A hit restamps the matching line; a miss refills the victim.
  always_comb begin
    hit_any      = |match;
    victim_dirty = 1'b0;
    stamp_new    = count_q + STAMP_W'(1);
    new_row      = rd_row_q;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (victim[w] && rd_row_q[w].valid && rd_row_q[w].dirty) begin
        victim_dirty = 1'b1;
      end
      if (hit_any) begin
        if (match[w]) begin
          new_row[w].stamp = stamp_new;
          if (policy_q == PolicyWriteBack && write_q == ModeWrite) begin
            new_row[w].dirty = 1'b1;
          end
        end
      end else if (victim[w]) begin
        new_row[w].valid = 1'b1;
        new_row[w].tag   = tag_q;
        new_row[w].stamp = stamp_new;
        // Write-through leaves the dirty bit alone.
        if (policy_q == PolicyWriteBack) begin
          new_row[w].dirty = write_q;
        end
      end
    end
    // A write-back write miss costs traffic only when a dirty line is evicted.
    if (policy_q == PolicyWriteBack) begin
      if (hit_any) begin
        new_hit = 1'b1;
      end else begin
        new_hit = (write_q == ModeWrite) ? !victim_dirty : 1'b0;
      end
    end else begin
      new_hit = hit_any && (write_q != ModeWrite);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_q == SET_W'(MAX_SETS - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          state_d = SETS_POW2 ? StLookup : StReduce;
        end
      end
      StReduce: state_d = StLookup;
      StLookup: state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Outputs of the control: memory ports and register updates.
  always_comb begin
    clr_d     = clr_q;
    tag_d     = tag_q;
    write_d   = write_q;
    set_d     = set_q;
    rem_d     = rem_q;
    count_d   = count_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    mem_re    = 1'b0;
    mem_raddr = set_direct;
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = new_row;
    case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + SET_W'(1);
      end
      StIdle: begin
        if (accept) begin
          tag_d   = req_tag;
          write_d = mode_i;
          set_d   = set_direct;
          rem_d   = idx_raw;
          mem_re  = SETS_POW2;
        end
      end
      StReduce: begin
        set_d     = SET_W'(rem_red);
        mem_re    = 1'b1;
        mem_raddr = SET_W'(rem_red);
      end
      StLookup: begin
        mem_we  = 1'b1;
        count_d = stamp_new;
        done_d  = 1'b1;
        hit_d   = new_hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q   <= tag_d;
    write_q <= write_d;
    set_q   <= set_d;
    rem_q   <= rem_d;
    hit_q   <= hit_d;
  end

  // Row memory: one write and one registered read per cycle, never to the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_q <= row_mem[mem_raddr];
    end
  end

endmodule

// ===== rtl/sacl_checker.sv =====
// Port-level checker for the tag store and its bind to the top level.
// Depends on set_assoc_lru_cache_tags being compiled before it.
module sacl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // An accepted item holds the block busy for at least the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // The result strobe lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A result comes only at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result outside the end of a busy period");

  // No result in the cycle right after an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_o)
    else $error("result came right after accept");

endmodule

bind set_assoc_lru_cache_tags sacl_checker u_sacl_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

// ===== test/tb_set_assoc_lru_cache_tags.sv =====
// Testbench for set_assoc_lru_cache_tags: drives cache accesses, predicts every hit/miss answer
// from its own copy of the tag store and compares each result item as it arrives.
// Depends on sacl_pkg and the RTL of set_assoc_lru_cache_tags; nothing else.
`timescale 1ns / 1ps

module tb_set_assoc_lru_cache_tags;
  import sacl_pkg::*;

  // Sizes of the tag store as built with default parameters.
  localparam int unsigned LINES       = MaxWaysDef * MaxSetsDef;
  // Generous bound on the whole run: the reset sweep plus all 824 queued items at worst pace.
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] addr;
    logic        wr;
  } access_t;

  // Clock, reset and DUT ports.
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start = 1'b0;
  logic                  busy;
  logic [31:0]           address_i = '0;
  logic                  mode_i = 1'b0;
  logic                  done_o;
  logic                  hit_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  always #2 clk_i = ~clk_i;

  set_assoc_lru_cache_tags DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .address_i  (address_i),
    .mode_i     (mode_i),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predictor state: a private copy of the registers and of every line of the store.
  logic        cfg_policy = PolicyWriteBack;
  logic [4:0]  cfg_off    = 5'd2;
  logic [3:0]  cfg_idx    = 4'd0;
  logic [3:0]  cfg_ways   = 4'd1;
  logic        valid_store [LINES];
  logic        dirty_store [LINES];
  logic [63:0] tag_store   [LINES];
  logic [31:0] stamp_store [LINES];
  logic [31:0] touch_count = '0;

  // Items waiting to be sent, and hit answers waiting to come back.
  access_t     pending_accesses[$];
  logic        hit_expected[$];

  int unsigned issued_count  = 0;
  int unsigned result_count  = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  logic        took_item     = 1'b0;

  // Sender shaping: bursts of random length, random gaps, and an occasional full drain.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  logic        hold_drain = 1'b0;
  logic        no_idle    = 1'b0;

  // Widths of the current phase, used to aim random addresses at a few busy sets.
  int unsigned gen_off  = 2;
  int unsigned gen_idx  = 0;
  int unsigned gen_ways = 1;

  initial begin
    for (int i = 0; i < LINES; i++) begin
      valid_store[i] = 1'b0;
      dirty_store[i] = 1'b0;
      tag_store[i]   = '0;
      stamp_store[i] = '0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Performs one access on the private store and returns the answer the block must give.
  function automatic logic predict_hit(input logic [31:0] addr, input logic wr);
    logic [63:0] a;
    logic [63:0] tg;
    logic [63:0] set_raw;
    int unsigned shamt;
    int unsigned ways;
    int unsigned base;
    int unsigned e;
    int unsigned victim;
    int unsigned w;
    logic        was_dirty;
    a       = {32'd0, addr};
    shamt   = int'(cfg_off) + int'(cfg_idx);
    ways    = (cfg_ways == 0) ? 1 : ((cfg_ways > MaxWaysDef) ? MaxWaysDef : cfg_ways);
    tg      = a >> shamt;
    set_raw = (a >> cfg_off) & ((64'd1 << cfg_idx) - 64'd1);
    base    = 32'(set_raw % MaxSetsDef) * MaxWaysDef;
    touch_count = touch_count + 32'd1;

    // Lookup across the ways in use; a match is stamped with the new count.
    for (w = 0; w < ways; w++) begin
      e = base + w;
      if (valid_store[e] && tag_store[e] == tg) begin
        stamp_store[e] = touch_count;
        if (cfg_policy == PolicyWriteBack) begin
          if (wr == ModeWrite) dirty_store[e] = 1'b1;
          return 1'b1;
        end
        return (wr == ModeWrite) ? 1'b0 : 1'b1;
      end
    end

    // Miss: first invalid way wins, otherwise the oldest stamp, lowest way on a tie.
    victim = base;
    for (w = 0; w < ways; w++) begin
      e = base + w;
      if (!valid_store[e]) begin
        victim = e;
        break;
      end
      if (stamp_store[e] < stamp_store[victim]) victim = e;
    end

    was_dirty           = valid_store[victim] && dirty_store[victim];
    valid_store[victim] = 1'b1;
    tag_store[victim]   = tg;
    stamp_store[victim] = touch_count;
    if (cfg_policy == PolicyWriteBack) begin
      if (wr == ModeWrite) begin
        // A write miss only costs memory traffic when a dirty line is evicted.
        dirty_store[victim] = 1'b1;
        return was_dirty ? 1'b0 : 1'b1;
      end
      dirty_store[victim] = 1'b0;
      return 1'b0;
    end
    // Write-through leaves dirty bits alone and answers miss on every miss.
    return 1'b0;
  endfunction

  // Monitor: checks result items, mirrors register writes and predicts each accepted item.
  // The result is checked before the accept at the same edge is predicted, since it always
  // belongs to an earlier item.
  always @(posedge clk_i) begin
    logic exp_hit;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
      $display("FAIL set_assoc_lru_cache_tags");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        result_count++;
        if (hit_expected.size() == 0) begin
          report_mismatch($sformatf("result item %0d arrived with none expected", result_count));
        end else begin
          exp_hit = hit_expected.pop_front();
          if (hit_o !== exp_hit)
            report_mismatch($sformatf("result item %0d: hit expected %0b, got %0b",
                                      result_count, exp_hit, hit_o));
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CfgWritePolicy: begin
            cfg_policy = cfg_wdata_i[0];
          end
          CfgOffsetBits: begin
            cfg_off = cfg_wdata_i[4:0];
          end
          CfgIndexBits: begin
            cfg_idx = cfg_wdata_i[3:0];
          end
          CfgWaysInUse: begin
            cfg_ways = cfg_wdata_i[3:0];
          end
          default: begin
          end
        endcase
      end
      if (start && !busy) hit_expected.push_back(predict_hit(address_i, mode_i));
      took_item <= start && !busy;
    end else begin
      took_item <= 1'b0;
    end
  end

  // Driver: presents the next pending item at the falling edge and holds it until taken.
  // Between bursts it idles for a random number of cycles; now and then it waits for every
  // outstanding answer before sending again.
  always @(negedge clk_i) begin
    access_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (hold_drain && hit_expected.size() != 0) begin
        start <= 1'b0;
      end else if (pending_accesses.size() != 0) begin
        nxt        = pending_accesses.pop_front();
        address_i <= nxt.addr;
        mode_i    <= nxt.wr;
        start     <= 1'b1;
        hold_drain = ($urandom_range(0, 63) == 0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = no_idle ? 0 : $urandom_range(0, 7);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_access(input logic [31:0] addr, input logic wr);
    access_t a;
    a.addr = addr;
    a.wr   = wr;
    pending_accesses.push_back(a);
    issued_count++;
  endtask

  // Waits until every queued item has been answered, then lets the pipeline settle.
  task automatic wait_all_done();
    while (result_count < issued_count) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(input logic policy, input int unsigned off, input int unsigned idxb,
                            input int unsigned ways);
    write_reg(CfgWritePolicy, CFG_DATA_W'(policy));
    write_reg(CfgOffsetBits, CFG_DATA_W'(off));
    write_reg(CfgIndexBits, CFG_DATA_W'(idxb));
    write_reg(CfgWaysInUse, CFG_DATA_W'(ways));
    gen_off  = off;
    gen_idx  = idxb;
    gen_ways = (ways == 0) ? 1 : ((ways > MaxWaysDef) ? MaxWaysDef : ways);
  endtask

  // Most addresses reuse a handful of tags in a few sets so that hits, evictions and
  // dirty victims all occur; some sets sit 256 above to alias, and a tenth are fully random.
  function automatic logic [31:0] random_address();
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] lo;
    if ($urandom_range(0, 9) == 0) return $urandom;
    t  = ($urandom_range(0, 19) == 0) ? 64'($urandom) : 64'($urandom_range(0, gen_ways + 2));
    s  = 64'($urandom_range(0, 3)) + (($urandom_range(0, 3) == 0) ? 64'd256 : 64'd0);
    lo = 64'($urandom);
    return 32'((t << (gen_off + gen_idx)) | ((s & ((64'd1 << gen_idx) - 64'd1)) << gen_off)
               | (lo & ((64'd1 << gen_off) - 64'd1)));
  endfunction

  task automatic run_random_phase(input logic policy, input int unsigned off,
                                  input int unsigned idxb, input int unsigned ways,
                                  input int unsigned count, input logic quiet);
    set_config(policy, off, idxb, ways);
    no_idle = quiet;
    for (int unsigned n = 0; n < count; n++)
      queue_access(random_address(), logic'($urandom_range(0, 1)));
    wait_all_done();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = CfgWritePolicy;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: write-back, 4-byte blocks, one set, one way. Covers read miss, read hit,
    // write hit, a write miss that evicts a dirty line and one that evicts a clean line.
    queue_access(32'h0000_0000, 1'b0);
    queue_access(32'h0000_0003, 1'b0);
    queue_access(32'h0000_0000, 1'b1);
    queue_access(32'hFFFF_FFFF, 1'b1);
    queue_access(32'h0000_0010, 1'b0);
    queue_access(32'h0000_0020, 1'b1);
    queue_access(32'h0000_0020, 1'b1);
    queue_access(32'hFFFF_FFFC, 1'b0);
    wait_all_done();

    // Write-through with offset and index widths past the address width, so every tag is
    // zero, and a way count of zero that must act as one.
    set_config(PolicyWriteThrough, 31, 8, 0);
    queue_access(32'h0000_0000, 1'b0);
    queue_access(32'h8000_0000, 1'b0);
    queue_access(32'h7FFF_FFFF, 1'b1);
    queue_access(32'h0000_0000, 1'b0);
    wait_all_done();

    // Write-back with fifteen index bits: sets alias modulo the store, and a way count of
    // fifteen saturates to eight. Ten tags in set zero force LRU evictions.
    set_config(PolicyWriteBack, 0, 15, 15);
    queue_access(32'h0000_0000, 1'b0);
    queue_access(32'h0000_0100, 1'b1);
    for (int unsigned k = 1; k < 10; k++) queue_access(32'(k << 15), logic'(k[0]));
    queue_access(32'h0000_0000, 1'b0);
    wait_all_done();

    // Random part across a range of settings; lines carry over from phase to phase.
    run_random_phase(PolicyWriteBack,    2, 0, 1,  60, 1'b0);
    run_random_phase(PolicyWriteBack,    4, 2, 4, 150, 1'b0);
    run_random_phase(PolicyWriteBack,    6, 3, 8, 150, 1'b0);
    run_random_phase(PolicyWriteThrough, 5, 1, 2, 100, 1'b0);
    run_random_phase(PolicyWriteBack,    0, 8, 8,  80, 1'b0);
    run_random_phase(PolicyWriteBack,   31, 0, 3,  40, 1'b0);
    run_random_phase(PolicyWriteThrough, 3, 4, 8,  80, 1'b1);
    run_random_phase(PolicyWriteBack,    2, 15, 15, 60, 1'b0);
    run_random_phase(PolicyWriteBack,    1, 2, 0,  40, 1'b0);
    run_random_phase(PolicyWriteThrough, 0, 0, 1,  40, 1'b0);

    repeat (8) @(negedge clk_i);
    if (hit_expected.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", hit_expected.size()));
    if (error_count == 0) begin
      $display("PASS set_assoc_lru_cache_tags");
    end else begin
      $display("FAIL set_assoc_lru_cache_tags");
    end
    $finish;
  end

endmodule

// ===== set_assoc_lru_cache_tags.f =====
rtl/sacl_pkg.sv
rtl/sacl_lookup.sv
rtl/set_assoc_lru_cache_tags.sv
rtl/sacl_checker.sv
test/tb_set_assoc_lru_cache_tags.sv
